FILE: sv/fism_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fism_pkg
// Shared types, opcodes and Fenwick-tree set functions for the
// index set mask generator.
// ----------------------------------------------------------------------------
package fism_pkg;

  localparam int unsigned MaxQubits = 64;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CountW    = 7;
  localparam int unsigned MaskW     = MaxQubits;

  // request opcodes
  typedef enum logic [3:0] {
    OpOcc        = 4'd0,
    OpPar        = 4'd1,
    OpUpd        = 4'd2,
    OpRem        = 4'd3,
    OpF          = 4'd4,
    OpP0         = 4'd5,
    OpP1         = 4'd6,
    OpP2         = 4'd7,
    OpP3         = 4'd8,
    OpU          = 4'd9,
    OpAlpha      = 4'd10,
    OpUMinusA    = 4'd11,
    OpP0XorAlpha = 4'd12
  } fism_op_e;

  // one result item
  typedef struct packed {
    logic               index_error;
    logic               j_in_update_of_i;
    logic               i_in_parity_of_j;
    logic [CountW-1:0]  set_size;
    logic [MaskW-1:0]   set_mask;
  } fism_res_t;

  // occupation set: x itself, plus y-1 for each prefix of x that ends in
  // one of its trailing one bits
  function automatic logic [MaskW-1:0] occ_mask(input logic [IdxW-1:0] x);
    logic [MaskW-1:0] m;
    logic [IdxW-1:0]  y;
    logic             run;
    m   = '0;
    m[x] = 1'b1;
    run = 1'b1;
    for (int p = 0; p < IdxW; p++) begin
      run = run & x[p];
      y   = x & ~((IdxW'(1) << p) - IdxW'(1));
      if (run) begin
        m[y - IdxW'(1)] = 1'b1;
      end
    end
    return m;
  endfunction

  // parity set: y-1 for each nonzero value met while clearing low bits
  function automatic logic [MaskW-1:0] par_mask(input logic [IdxW-1:0] x);
    logic [MaskW-1:0] m;
    logic [IdxW-1:0]  y;
    m = '0;
    for (int p = 0; p < IdxW; p++) begin
      y = x & ~((IdxW'(1) << p) - IdxW'(1));
      if (x[p]) begin
        m[y - IdxW'(1)] = 1'b1;
      end
    end
    return m;
  endfunction

  // update set: each carry step of x+1 lands on a zero bit above the
  // lowest set bit; every landing value up to n contributes value-1
  function automatic logic [MaskW-1:0] upd_mask(input logic [IdxW-1:0]   x,
                                                input logic [CountW-1:0] n);
    logic [MaskW-1:0]  m;
    logic [CountW-1:0] y0;
    logic [CountW-1:0] below;
    logic [CountW-1:0] upto;
    logic [CountW-1:0] y;
    m  = '0;
    y0 = {1'b0, x} + CountW'(1);
    for (int p = 0; p < CountW; p++) begin
      below = CountW'((8'd1 << p) - 8'd1);
      upto  = CountW'((8'd1 << (p + 1)) - 8'd1);
      y     = (y0 & ~upto) | (CountW'(1) << p);
      if (!y0[p] && ((y0 & below) != '0) && (y <= n)) begin
        m[IdxW'(y - CountW'(1))] = 1'b1;
      end
    end
    return m;
  endfunction

  // population count: per-byte counts, then a sum of the bytes
  function automatic logic [CountW-1:0] pop_count(input logic [MaskW-1:0] v);
    logic [3:0]        bc;
    logic [CountW-1:0] total;
    total = '0;
    for (int b = 0; b < MaskW / 8; b++) begin
      bc = '0;
      for (int k = 0; k < 8; k++) begin
        bc = bc + 4'(v[8*b+k]);
      end
      total = total + CountW'(bc);
    end
    return total;
  endfunction

endpackage

FILE: sv/fism_sets.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fism_sets
// Combinational set builder: decodes the opcode, forms the selected mask,
// its population count, the membership flags and the range error.
// ----------------------------------------------------------------------------
module fism_sets (
  input  logic [3:0]                    opcode_i,
  input  logic [fism_pkg::IdxW-1:0]     first_index_i,
  input  logic [fism_pkg::IdxW-1:0]     second_index_i,
  input  logic [fism_pkg::CountW-1:0]   eff_count_i,
  output fism_pkg::fism_res_t           res_o
);
  import fism_pkg::*;

  logic [MaskW-1:0] occ_i, occ_j, par_i, par_j, upd_i, upd_j;
  logic [MaskW-1:0] rem_i, rem_j, alpha, mask;
  logic             bad_i, bad_j, err;
  fism_op_e         op;

  // base sets of both indices
  always_comb begin
    occ_i = occ_mask(first_index_i);
    occ_j = occ_mask(second_index_i);
    par_i = par_mask(first_index_i);
    par_j = par_mask(second_index_i);
    upd_i = upd_mask(first_index_i, eff_count_i);
    upd_j = upd_mask(second_index_i, eff_count_i);
    rem_i = par_i & ~occ_i;
    rem_j = par_j & ~occ_j;
    alpha = upd_i & par_j;
  end

  assign bad_i = {1'b0, first_index_i} >= eff_count_i;
  assign bad_j = {1'b0, second_index_i} >= eff_count_i;
  assign op    = fism_op_e'(opcode_i);

  // opcode select
  always_comb begin
    mask = '0;
    err  = bad_i | bad_j;
    case (op)
      OpOcc: begin
        mask = occ_i;
        err  = bad_i;
      end
      OpPar: begin
        mask = par_i;
        err  = bad_i;
      end
      OpUpd: begin
        mask = upd_i;
        err  = bad_i;
      end
      OpRem: begin
        mask = rem_i;
        err  = bad_i;
      end
      OpF:          mask = occ_i ^ occ_j;
      OpP0:         mask = par_i ^ par_j;
      OpP1:         mask = par_i ^ rem_j;
      OpP2:         mask = rem_i ^ par_j;
      OpP3:         mask = rem_i ^ rem_j;
      OpU:          mask = upd_i ^ upd_j;
      OpAlpha:      mask = alpha;
      OpUMinusA:    mask = (upd_i ^ upd_j) & ~alpha;
      OpP0XorAlpha: mask = par_i ^ par_j ^ alpha;
      default: begin
        mask = '0;
        err  = 1'b0;
      end
    endcase
  end

  // result assembly
  always_comb begin
    res_o.set_mask         = mask;
    res_o.set_size         = pop_count(mask);
    res_o.i_in_parity_of_j = par_j[first_index_i];
    res_o.j_in_update_of_i = upd_i[second_index_i];
    res_o.index_error      = err;
  end

endmodule

FILE: sv/fenwick_index_set_masks_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_index_set_masks_core
// Fenwick-tree (Bravyi-Kitaev) index set mask generator with stream ports
// and an APB-style register for the qubit count.
// ----------------------------------------------------------------------------
// Each request item carries an opcode and two qubit indices and yields one
// result item: a 64-bit mask of the selected index set, its member count,
// two membership flags and a range error flag. The block is a two-register
// pipeline (request register, result register) with one pass of mask logic
// between them, so it takes one item per clock cycle while the result side
// does not stall; a result item is computed from the request register and
// captured in the result register. Stalls on the result side hold the
// pipeline. qubit_count sits at byte address 0, resets to 64, values above
// 64 act as 64, and should be changed only while no items are in flight.
// ----------------------------------------------------------------------------
module fenwick_index_set_masks_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request: [3:0] opcode, [9:4] first_index, [15:10] second_index
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // result: [63:0] set_mask, [70:64] set_size, [71] i_in_parity_of_j,
  // [72] j_in_update_of_i, [73] index_error, [79:74] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fism_pkg::*;

  localparam logic [2:0] AddrQubitCount = 3'd0;

  logic [CountW-1:0] qubit_count_q, eff_count;
  logic              req_valid_q, res_valid_q;
  logic [15:0]       req_q;
  fism_res_t         res_d, res_q;
  logic              res_ready, req_ready;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == AddrQubitCount) ? {25'd0, qubit_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qubit_count_q <= CountW'(MaxQubits);
    end else if (psel && penable && pwrite && pready && paddr == AddrQubitCount) begin
      qubit_count_q <= pwdata[CountW-1:0];
    end
  end

  assign eff_count = (qubit_count_q > CountW'(MaxQubits)) ? CountW'(MaxQubits)
                                                          : qubit_count_q;

  // pipeline flow control
  assign res_ready     = !res_valid_q || m_axis_tready;
  assign req_ready     = !req_valid_q || res_ready;
  assign s_axis_tready = req_ready;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_ready) begin
      req_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready && s_axis_tvalid) begin
      req_q <= s_axis_tdata;
    end
  end

  // set logic
  fism_sets u_sets (
    .opcode_i       (req_q[3:0]),
    .first_index_i  (req_q[9:4]),
    .second_index_i (req_q[15:10]),
    .eff_count_i    (eff_count),
    .res_o          (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {6'd0, res_q.index_error, res_q.j_in_update_of_i,
                          res_q.i_in_parity_of_j, res_q.set_size, res_q.set_mask};

endmodule

FILE: dv/fism_set_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fism_set_checker
// Watches the request, result and register channels of the Fenwick index
// set mask core. It keeps its own copy of the qubit count, works out each
// request's mask, size and flags, and compares them with the results in
// order.
// ----------------------------------------------------------------------------
module fism_set_checker
  import fism_pkg::*;
#(
  parameter logic [2:0] QubitCountAddr = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request: [3:0] opcode, [9:4] first_index, [15:10] second_index
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // result: [63:0] set_mask, [70:64] set_size, [71] i_in_parity_of_j,
  // [72] j_in_update_of_i, [73] index_error, [79:74] zero
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          error_count_o,
  output int          pending_o,
  output int          checked_o
);

  fism_res_t         expected_sets[$];
  logic [CountW-1:0] qubit_count;

  // single qubit position, dropped beyond the mask width
  function automatic logic [MaskW-1:0] qubit_bit(int unsigned k);
    if (k >= MaskW) begin
      return '0;
    end
    return MaskW'(1) << k;
  endfunction

  // occupation set: x plus y-1 while clearing low bits down to x's trailing-ones floor
  function automatic logic [MaskW-1:0] occ_walk(int unsigned x);
    logic [MaskW-1:0] m;
    int unsigned      floor_val;
    int unsigned      y;
    m         = qubit_bit(x);
    floor_val = (x + 1) & x;
    y         = x;
    while (y != floor_val) begin
      m |= qubit_bit(y - 1);
      y &= y - 1;
    end
    return m;
  endfunction

  // parity set: y-1 for each nonzero y while clearing low bits
  function automatic logic [MaskW-1:0] par_walk(int unsigned x);
    logic [MaskW-1:0] m;
    int unsigned      y;
    m = '0;
    y = x;
    while (y > 0) begin
      m |= qubit_bit(y - 1);
      y &= y - 1;
    end
    return m;
  endfunction

  // update set: climb by the lowest set bit, bounded by the qubit count
  function automatic logic [MaskW-1:0] upd_walk(int unsigned x, int unsigned n);
    logic [MaskW-1:0] m;
    int unsigned      y;
    m = '0;
    y = x + 1;
    y += y & (0 - y);
    while (y <= n) begin
      m |= qubit_bit(y - 1);
      y += y & (0 - y);
    end
    return m;
  endfunction

  // full result of one request under a given qubit count
  function automatic fism_res_t index_set_result(logic [3:0] op, logic [IdxW-1:0] i,
                                                 logic [IdxW-1:0] j,
                                                 logic [CountW-1:0] count);
    int unsigned      n;
    logic [MaskW-1:0] par_i, par_j, rem_i, rem_j, upd_i, upd_j, alpha, m;
    logic             bad_i, bad_j, err;
    fism_res_t        r;
    n     = (count > MaxQubits) ? MaxQubits : count;
    bad_i = i >= n;
    bad_j = j >= n;
    par_i = par_walk(i);
    par_j = par_walk(j);
    rem_i = par_i & ~occ_walk(i);
    rem_j = par_j & ~occ_walk(j);
    upd_i = upd_walk(i, n);
    upd_j = upd_walk(j, n);
    alpha = upd_i & par_j;
    err   = bad_i | bad_j;
    case (fism_op_e'(op))
      OpOcc: begin
        m   = occ_walk(i);
        err = bad_i;
      end
      OpPar: begin
        m   = par_i;
        err = bad_i;
      end
      OpUpd: begin
        m   = upd_i;
        err = bad_i;
      end
      OpRem: begin
        m   = rem_i;
        err = bad_i;
      end
      OpF:          m = occ_walk(i) ^ occ_walk(j);
      OpP0:         m = par_i ^ par_j;
      OpP1:         m = par_i ^ rem_j;
      OpP2:         m = rem_i ^ par_j;
      OpP3:         m = rem_i ^ rem_j;
      OpU:          m = upd_i ^ upd_j;
      OpAlpha:      m = alpha;
      OpUMinusA:    m = (upd_i ^ upd_j) & ~alpha;
      OpP0XorAlpha: m = par_i ^ par_j ^ alpha;
      default: begin
        m   = '0;
        err = 1'b0;
      end
    endcase
    r.set_mask         = m;
    r.set_size         = CountW'($countones(m));
    r.i_in_parity_of_j = |(par_j & qubit_bit(i));
    r.j_in_update_of_i = |(upd_i & qubit_bit(j));
    r.index_error      = err;
    return r;
  endfunction

  // one field compare, reported with time, expected and actual
  task automatic compare_field(string field, logic [MaskW-1:0] exp_v, logic [MaskW-1:0] act_v);
    if (act_v !== exp_v) begin
      error_count_o++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
    end
  endtask

  // predict on request items, check result items, follow register writes
  always @(posedge clk_i or negedge rst_ni) begin
    fism_res_t exp_r;
    fism_res_t act_r;
    if (!rst_ni) begin
      expected_sets.delete();
      qubit_count   = CountW'(MaxQubits);
      error_count_o = 0;
      checked_o     = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_sets.push_back(index_set_result(s_axis_tdata[3:0], s_axis_tdata[9:4],
                                                 s_axis_tdata[15:10], qubit_count));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act_r = fism_res_t'(m_axis_tdata[$bits(fism_res_t)-1:0]);
        if (expected_sets.size() == 0) begin
          error_count_o++;
          $display("%0t ns: result with nothing expected, actual %h", $time, m_axis_tdata);
        end else begin
          exp_r = expected_sets.pop_front();
          checked_o++;
          compare_field("set_mask", exp_r.set_mask, act_r.set_mask);
          compare_field("set_size", MaskW'(exp_r.set_size), MaskW'(act_r.set_size));
          compare_field("i_in_parity_of_j", MaskW'(exp_r.i_in_parity_of_j),
                        MaskW'(act_r.i_in_parity_of_j));
          compare_field("j_in_update_of_i", MaskW'(exp_r.j_in_update_of_i),
                        MaskW'(act_r.j_in_update_of_i));
          compare_field("index_error", MaskW'(exp_r.index_error),
                        MaskW'(act_r.index_error));
        end
      end
      if (psel && penable && pwrite && pready && paddr == QubitCountAddr) begin
        qubit_count = pwdata[CountW-1:0];
      end
    end
    pending_o = expected_sets.size();
  end

endmodule

FILE: dv/tb_fenwick_index_set_masks_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fenwick_index_set_masks_core
// Drives directed and random mask requests through the core under a range
// of qubit counts, with bursty requests and a stalling result side; a
// checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fenwick_index_set_masks_core;
  import fism_pkg::*;

  localparam logic [2:0] QubitCountAddr = 3'd0;
  localparam logic [3:0] OpUndefLo      = 4'd13;
  localparam logic [3:0] OpUndefHi      = 4'd15;
  localparam int         NumPhases      = 10;
  localparam int         PhaseItems     = 100;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatch_count;
  int          results_pending;
  int          results_checked;
  int          readback_errors = 0;
  int          items_sent      = 0;
  int          burst_left      = 0;
  int          settings_used   = 1;

  // receiver stall state
  int          stall_mode      = 0;
  int          stall_left      = 0;
  logic [7:0]  stall_pattern   = 8'hFF;

  always #10 clk_i = ~clk_i;

  fenwick_index_set_masks_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  fism_set_checker #(
    .QubitCountAddr (QubitCountAddr)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .error_count_o (mismatch_count),
    .pending_o     (results_pending),
    .checked_o     (results_checked)
  );

  // result-side stalls in randomly chosen modes
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode    = $urandom_range(0, 4);
      stall_left    = $urandom_range(20, 80);
      stall_pattern = 8'($urandom);
    end
    stall_left--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: begin
        m_axis_tready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      end
      3: m_axis_tready <= ($urandom_range(0, 7) != 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // one request item; returns on the falling edge after acceptance
  task automatic send_request(logic [3:0] op, logic [IdxW-1:0] i, logic [IdxW-1:0] j);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {j, i, op};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  // bursts of requests separated by random idle gaps
  task automatic send_bursty(logic [3:0] op, logic [IdxW-1:0] i, logic [IdxW-1:0] j);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 16'($urandom);
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    send_request(op, i, j);
  endtask

  // stop sending and let every outstanding result drain
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 16'($urandom);
    while (results_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // register write then read-back, both from a falling edge
  task automatic set_qubit_count(logic [CountW-1:0] count);
    logic [31:0] rd;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= QubitCountAddr;
    pwdata  <= {$urandom_range(0, 1) ? 25'h1FFFFFF : 25'h0, count};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {25'h0, count}) begin
      readback_errors++;
      $display("%0t ns: qubit_count read-back mismatch, expected %h actual %h",
               $time, {25'h0, count}, rd);
    end
  endtask

  // uniform random indices, indices near the qubit count, all-ones patterns and the extremes
  function automatic logic [IdxW-1:0] pick_index(logic [CountW-1:0] count);
    int v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom_range(0, 63);
      2:    v = int'(count) + $urandom_range(0, 2) - 1;
      3:    v = (1 << $urandom_range(0, IdxW)) - 1;
      default: v = $urandom_range(0, 1) ? 63 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return IdxW'(v);
  endfunction

  initial begin
    logic [CountW-1:0] count;
    logic [3:0]        op;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: every opcode with extreme indices at the reset count
    for (int k = 0; k <= OpUndefHi; k++) begin
      op = 4'(k);
      send_request(op, op[0] ? 6'd0 : 6'd63, op[0] ? 6'd63 : 6'd0);
    end
    send_request(OpAlpha, 6'd63, 6'd63);
    send_request(OpU, 6'd0, 6'd0);
    send_request(OpUMinusA, 6'd42, 6'd21);
    send_request(OpP0XorAlpha, 6'd21, 6'd42);
    send_request(OpF, 6'd31, 6'd32);
    send_request(OpP3, 6'd47, 6'd15);
    drain_results();

    // random phases: extremes of the count first, then random counts
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: count = 7'd1;
        1: count = 7'd0;
        2: count = 7'd127;
        3: count = 7'd65;
        4: count = 7'd2;
        5: count = 7'd33;
        6: count = 7'd63;
        7: count = 7'd64;
        default: count = $urandom_range(1, 64);
      endcase
      set_qubit_count(count);
      settings_used++;
      for (int k = 0; k < PhaseItems; k++) begin
        op = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(OpOcc, OpP0XorAlpha))
                                         : 4'($urandom_range(OpUndefLo, OpUndefHi));
        send_bursty(op, pick_index(count), pick_index(count));
      end
      drain_results();
    end

    repeat (8) @(negedge clk_i);
    $display("summary: %0d requests under %0d qubit-count settings, %0d results compared",
             items_sent, settings_used, results_checked);
    if (mismatch_count == 0 && readback_errors == 0) begin
      $display("tb_fenwick_index_set_masks_core: done, clean");
    end else begin
      $display("tb_fenwick_index_set_masks_core: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("tb_fenwick_index_set_masks_core: done, errors");
    $finish;
  end

endmodule
